// ===== rtl/sync_length_frame_receiver_assert.svh =====
// ----------------------------------------------------------------------------
// sync_length_frame_receiver_assert.svh
// assertion macros used by the frame receiver parser
// ----------------------------------------------------------------------------
`ifndef SYNC_LENGTH_FRAME_RECEIVER_ASSERT_SVH
`define SYNC_LENGTH_FRAME_RECEIVER_ASSERT_SVH

`ifndef ASSERT_OFF
// clocked property check, disabled while reset is held
`define SLFR_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("slfr assertion failed");
// same check with a message of the caller's choice
`define SLFR_ASSERT_MSG(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);
`else
`define SLFR_ASSERT(lbl, clk, rst_n, prop)
`define SLFR_ASSERT_MSG(lbl, clk, rst_n, prop, msg)
`endif

`endif

// ===== rtl/slfr_pkg.sv =====
// ----------------------------------------------------------------------------
// slfr_pkg
// types and constants of the sync/length frame receiver
// ----------------------------------------------------------------------------
package slfr_pkg;

    // request kinds on the input stream
    localparam logic REQ_BYTE = 1'b0;
    localparam logic REQ_TICK = 1'b1;

    // configuration register indexes
    localparam logic [2:0] CFG_SYNC_BYTE      = 3'd0;
    localparam logic [2:0] CFG_STD_TYPE_BYTE  = 3'd1;
    localparam logic [2:0] CFG_CMD_TYPE_BYTE  = 3'd2;
    localparam logic [2:0] CFG_MAX_STD_LENGTH = 3'd3;
    localparam logic [2:0] CFG_MAX_CMD_LENGTH = 3'd4;
    localparam logic [2:0] CFG_STALL_TIMEOUT  = 3'd5;

    // byte positions within a frame
    localparam logic [16:0] POS_SYNC    = 17'd0;
    localparam logic [16:0] POS_TYPE    = 17'd1;
    localparam logic [16:0] POS_LEN_HI  = 17'd2;
    localparam logic [16:0] POS_LEN_LO  = 17'd3;
    localparam logic [16:0] POS_PAYLOAD = 17'd4;

    typedef enum logic [1:0] {
        ST_NONE        = 2'd0,
        ST_LEN_REJECT  = 2'd1,
        ST_STALL_ABORT = 2'd2,
        ST_BAD_TYPE    = 2'd3
    } t_status;

    typedef struct packed {
        logic [7:0]  sync_byte;
        logic [7:0]  std_type_byte;
        logic [7:0]  cmd_type_byte;
        logic [15:0] max_std_length;
        logic [15:0] max_cmd_length;
        logic [15:0] stall_timeout;
    } t_cfg;

    typedef struct packed {
        logic        payload_valid;
        logic [7:0]  payload_byte;
        logic        frame_kind;
        logic        frame_done;
        logic [15:0] frame_length;
        t_status     status;
        logic        window_active;
    } t_result;

endpackage

// ===== rtl/slfr_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// slfr_cfg_regs
// configuration register file written through the config channel
// ----------------------------------------------------------------------------
module slfr_cfg_regs
    import slfr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    output logic        o_cfg_ready,
    output t_cfg        o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    // writes are always taken
    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    // decode the register index
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_SYNC_BYTE:      n_cfg.sync_byte      = i_cfg_data[7:0];
                CFG_STD_TYPE_BYTE:  n_cfg.std_type_byte  = i_cfg_data[7:0];
                CFG_CMD_TYPE_BYTE:  n_cfg.cmd_type_byte  = i_cfg_data[7:0];
                CFG_MAX_STD_LENGTH: n_cfg.max_std_length = i_cfg_data;
                CFG_MAX_CMD_LENGTH: n_cfg.max_cmd_length = i_cfg_data;
                CFG_STALL_TIMEOUT:  n_cfg.stall_timeout  = i_cfg_data;
                default:            n_cfg = r_cfg;
            endcase
        end
    end

    // register file with reset values
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sync_byte      <= 8'd148;
            r_cfg.std_type_byte  <= 8'd195;
            r_cfg.cmd_type_byte  <= 8'd0;
            r_cfg.max_std_length <= 16'd512;
            r_cfg.max_cmd_length <= 16'd256;
            r_cfg.stall_timeout  <= 16'd1000;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

// ===== rtl/slfr_in_reg.sv =====
// ----------------------------------------------------------------------------
// slfr_in_reg
// input register stage holding one request until the parser takes it
// ----------------------------------------------------------------------------
module slfr_in_reg
    import slfr_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] data_byte
    input  logic       s_axis_tuser,   // [0] req_type
    input  logic       i_take,
    output logic       o_valid,
    output logic       o_req_type,
    output logic [7:0] o_data_byte
);

    logic       r_valid;
    logic       r_req_type;
    logic [7:0] r_data_byte;
    logic       n_valid;
    logic       w_accept;

    // free when empty or when the held request moves on this cycle
    assign s_axis_tready = !r_valid || i_take;
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    always_comb begin
        n_valid = r_valid;
        if (w_accept) begin
            n_valid = 1'b1;
        end else if (i_take) begin
            n_valid = 1'b0;
        end
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_req_type  <= s_axis_tuser;
            r_data_byte <= s_axis_tdata;
        end
    end

    assign o_valid     = r_valid;
    assign o_req_type  = r_req_type;
    assign o_data_byte = r_data_byte;

endmodule

// ===== rtl/slfr_parser.sv =====
// ----------------------------------------------------------------------------
// slfr_parser
// frame state and per-request decode: sync, type, length, payload, timeout
// ----------------------------------------------------------------------------
`include "sync_length_frame_receiver_assert.svh"

module slfr_parser
    import slfr_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_advance,
    input  logic       i_req_type,
    input  logic [7:0] i_data_byte,
    input  t_cfg       i_cfg,
    output t_result    o_result
);

    logic [16:0] r_pos;
    logic [7:0]  r_len_hi;
    logic [15:0] r_plen;
    logic        r_kind_cmd;
    logic        r_window;
    logic [15:0] r_stall;

    logic [16:0] n_pos;
    logic [7:0]  n_len_hi;
    logic [15:0] n_plen;
    logic        n_kind_cmd;
    logic        n_window;
    logic [15:0] n_stall;

    logic [15:0] w_len;
    logic [15:0] w_limit;
    logic        w_last;
    t_result     w_res;

    assign w_len   = {r_len_hi, i_data_byte};
    assign w_limit = r_kind_cmd ? i_cfg.max_cmd_length : i_cfg.max_std_length;
    // payload position reaches the final byte of the frame
    assign w_last  = ({1'b0, r_pos} + 18'd1) >= ({2'b00, r_plen} + 18'd4);

    // next state and result for the held request
    always_comb begin
        n_pos      = r_pos;
        n_len_hi   = r_len_hi;
        n_plen     = r_plen;
        n_kind_cmd = r_kind_cmd;
        n_window   = r_window;
        n_stall    = r_stall;
        w_res      = '0;
        w_res.status = ST_NONE;

        if (i_req_type == REQ_TICK) begin
            // tick only matters while a command window is open
            if (r_window) begin
                n_stall = r_stall + 16'd1;
                if (n_stall >= i_cfg.stall_timeout) begin
                    n_pos            = POS_SYNC;
                    n_window         = 1'b0;
                    w_res.status     = ST_STALL_ABORT;
                    w_res.frame_kind = 1'b1;
                end
            end
        end else begin
            case (r_pos)
                POS_SYNC: begin
                    if (i_data_byte == i_cfg.sync_byte) begin
                        n_pos = POS_TYPE;
                    end
                end
                POS_TYPE: begin
                    if (i_data_byte == i_cfg.std_type_byte) begin
                        n_kind_cmd = 1'b0;
                        n_window   = 1'b0;
                        n_pos      = POS_LEN_HI;
                    end else if (i_data_byte == i_cfg.cmd_type_byte) begin
                        n_kind_cmd = 1'b1;
                        n_window   = 1'b1;
                        n_stall    = 16'd0;
                        n_pos      = POS_LEN_HI;
                    end else begin
                        n_pos        = POS_SYNC;
                        n_window     = 1'b0;
                        w_res.status = ST_BAD_TYPE;
                    end
                end
                POS_LEN_HI: begin
                    n_len_hi = i_data_byte;
                    n_pos    = POS_LEN_LO;
                end
                POS_LEN_LO: begin
                    n_plen             = w_len;
                    w_res.frame_kind   = r_kind_cmd;
                    w_res.frame_length = w_len;
                    if (w_len > w_limit) begin
                        n_pos        = POS_SYNC;
                        n_window     = 1'b0;
                        w_res.status = ST_LEN_REJECT;
                    end else if (w_len == 16'd0) begin
                        // empty frame ends on its length byte
                        w_res.frame_done = 1'b1;
                        n_pos            = POS_SYNC;
                        if (r_kind_cmd) begin
                            n_window = 1'b0;
                        end
                    end else begin
                        n_pos = POS_PAYLOAD;
                    end
                end
                default: begin
                    w_res.payload_valid = 1'b1;
                    w_res.payload_byte  = i_data_byte;
                    w_res.frame_kind    = r_kind_cmd;
                    w_res.frame_length  = r_plen;
                    if (w_last) begin
                        w_res.frame_done = 1'b1;
                        n_pos            = POS_SYNC;
                        if (r_kind_cmd) begin
                            n_window = 1'b0;
                        end
                    end else begin
                        n_pos = r_pos + 17'd1;
                    end
                end
            endcase
        end
        w_res.window_active = n_window;
    end

    assign o_result = w_res;

    // frame state, updated when the request moves to the result stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos      <= POS_SYNC;
            r_len_hi   <= 8'd0;
            r_plen     <= 16'd0;
            r_kind_cmd <= 1'b0;
            r_window   <= 1'b0;
            r_stall    <= 16'd0;
        end else if (i_advance) begin
            r_pos      <= n_pos;
            r_len_hi   <= n_len_hi;
            r_plen     <= n_plen;
            r_kind_cmd <= n_kind_cmd;
            r_window   <= n_window;
            r_stall    <= n_stall;
        end
    end

    // payload position never runs past the last byte of the frame
    `SLFR_ASSERT_MSG(a_pos_in_frame, i_clk, i_rst_n,
        (r_pos >= POS_PAYLOAD) |-> (({1'b0, r_pos} + 18'd1) <= ({2'b00, r_plen} + 18'd4)),
        "payload position beyond frame length")
    // an open window always belongs to a command frame
    `SLFR_ASSERT(a_window_kind, i_clk, i_rst_n, r_window |-> r_kind_cmd)
    // the window is closed whenever the parser is hunting for sync
    `SLFR_ASSERT(a_window_hunt, i_clk, i_rst_n, r_window |-> (r_pos != POS_SYNC))
    // a stall abort always leaves the window closed
    `SLFR_ASSERT(a_abort_closes, i_clk, i_rst_n,
        (i_advance && (w_res.status == ST_STALL_ABORT)) |=> !r_window)

endmodule

// ===== rtl/slfr_out_reg.sv =====
// ----------------------------------------------------------------------------
// slfr_out_reg
// result register driving the master stream
// ----------------------------------------------------------------------------
module slfr_out_reg
    import slfr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_load,
    input  t_result     i_result,
    output logic        o_ready,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,  // [7:0] payload_byte, [23:8] frame_length,
                                       // [25:24] status, [26] window_active, rest 0
    output logic [1:0]  m_axis_tuser,  // [0] payload_valid, [1] frame_kind
    output logic        m_axis_tlast   // frame_done
);

    logic    r_valid;
    logic    n_valid;
    t_result r_result;

    // room for a new result when empty or the current one leaves now
    assign o_ready = !r_valid || m_axis_tready;

    always_comb begin
        n_valid = r_valid;
        if (i_load) begin
            n_valid = 1'b1;
        end else if (m_axis_tready) begin
            n_valid = 1'b0;
        end
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    // pack the result onto the stream
    assign m_axis_tvalid = r_valid;
    assign m_axis_tdata  = {5'd0, r_result.window_active, r_result.status,
                            r_result.frame_length, r_result.payload_byte};
    assign m_axis_tuser  = {r_result.frame_kind, r_result.payload_valid};
    assign m_axis_tlast  = r_result.frame_done;

endmodule

// ===== rtl/sync_length_frame_receiver.sv =====
// ----------------------------------------------------------------------------
// sync_length_frame_receiver
// sync-byte, length-prefixed frame receiver with command window timeout
// ----------------------------------------------------------------------------
// channel   direction  handshake                       contents
// s_axis    in         s_axis_tvalid / s_axis_tready   tdata byte, tuser 0 byte 1 tick
// m_axis    out        m_axis_tvalid / m_axis_tready   one result per request
// cfg       in         i_cfg_valid / o_cfg_ready       register index and data
//
// each request passes through the input register and then the result
// register; a request is accepted every cycle while results drain.
// the frame state advances as a request moves into the result register, so
// the single pass of decode logic between the two registers sets the rate.
// reset (synchronous, active low) clears the stages, the frame state and
// loads the register defaults; a stalled m_axis holds both stages.
// ----------------------------------------------------------------------------
module sync_length_frame_receiver
    import slfr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tuser,   // [0] req_type
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [7:0] payload_byte, [23:8] frame_length,
                                        // [25:24] status, [26] window_active
    output logic [1:0]  m_axis_tuser,   // [0] payload_valid, [1] frame_kind
    output logic        m_axis_tlast,   // frame_done
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    t_cfg       w_cfg;
    t_result    w_result;
    logic       w_in_valid;
    logic       w_req_type;
    logic [7:0] w_data_byte;
    logic       w_out_ready;
    logic       w_advance;

    // request moves from input to result register
    assign w_advance = w_in_valid && w_out_ready;

    slfr_cfg_regs u_cfg_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready),
        .o_cfg       (w_cfg)
    );

    slfr_in_reg u_in_reg (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .i_take        (w_advance),
        .o_valid       (w_in_valid),
        .o_req_type    (w_req_type),
        .o_data_byte   (w_data_byte)
    );

    slfr_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_advance   (w_advance),
        .i_req_type  (w_req_type),
        .i_data_byte (w_data_byte),
        .i_cfg       (w_cfg),
        .o_result    (w_result)
    );

    slfr_out_reg u_out_reg (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_load        (w_advance),
        .i_result      (w_result),
        .o_ready       (w_out_ready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

// ===== test/sync_length_frame_receiver_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sync_length_frame_receiver_tb
// self-checking bench for the sync/length frame receiver: a shadow decoder
// predicts one result per accepted request, a monitor compares every result
// field by field, and stimulus walks through defaults, header errors,
// register extremes, output back-pressure and randomized frame traffic
// ----------------------------------------------------------------------------
module sync_length_frame_receiver_tb
    import slfr_pkg::*;
();

    localparam int QUIET_LIMIT  = 4000;   // cycles with no handshake at all
    localparam int HOLD_CYCLES  = 400;    // long receiver hold-off
    localparam int RANDOM_ITEMS = 320;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;   // [7:0] data_byte
    logic        s_axis_tuser;   // [0] req_type
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;   // [7:0] payload_byte, [23:8] frame_length,
                                 // [25:24] status, [26] window_active
    logic [1:0]  m_axis_tuser;   // [0] payload_valid, [1] frame_kind
    logic        m_axis_tlast;   // frame_done
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index;
    logic [15:0] i_cfg_data;

    sync_length_frame_receiver i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    // shadow copy of the registers and the frame state
    t_cfg        shadow_cfg;
    logic [16:0] fr_pos;
    logic [7:0]  fr_len_hi;
    logic [15:0] fr_len;
    logic        fr_is_cmd;
    logic        fr_window;
    logic [15:0] fr_ticks;

    t_result     pending_results[$];
    int          errors;
    int          sent_count;
    bit          no_idle;
    bit          hold_req;
    int          quiet_cycles;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // decode one request and advance the shadow frame state
    function automatic t_result decode_step(input logic req, input logic [7:0] b);
        t_result     r;
        logic [15:0] len;
        logic [15:0] lim;
        r = '0;
        if (req == REQ_TICK) begin
            if (fr_window) begin
                fr_ticks = fr_ticks + 16'd1;
                if (fr_ticks >= shadow_cfg.stall_timeout) begin
                    fr_pos = POS_SYNC;
                    fr_window = 1'b0;
                    r.status = ST_STALL_ABORT;
                    r.frame_kind = 1'b1;
                end
            end
        end else if (fr_pos == POS_SYNC) begin
            if (b == shadow_cfg.sync_byte) fr_pos = POS_TYPE;
        end else if (fr_pos == POS_TYPE) begin
            if (b == shadow_cfg.std_type_byte) begin
                fr_is_cmd = 1'b0;
                fr_window = 1'b0;
                fr_pos = POS_LEN_HI;
            end else if (b == shadow_cfg.cmd_type_byte) begin
                fr_is_cmd = 1'b1;
                fr_window = 1'b1;
                fr_ticks = '0;
                fr_pos = POS_LEN_HI;
            end else begin
                fr_pos = POS_SYNC;
                fr_window = 1'b0;
                r.status = ST_BAD_TYPE;
            end
        end else if (fr_pos == POS_LEN_HI) begin
            fr_len_hi = b;
            fr_pos = POS_LEN_LO;
        end else if (fr_pos == POS_LEN_LO) begin
            len = {fr_len_hi, b};
            lim = fr_is_cmd ? shadow_cfg.max_cmd_length : shadow_cfg.max_std_length;
            fr_len = len;
            r.frame_kind = fr_is_cmd;
            r.frame_length = len;
            if (len > lim) begin
                fr_pos = POS_SYNC;
                fr_window = 1'b0;
                r.status = ST_LEN_REJECT;
            end else if (len == 16'd0) begin
                r.frame_done = 1'b1;
                fr_pos = POS_SYNC;
                if (fr_is_cmd) fr_window = 1'b0;
            end else begin
                fr_pos = POS_PAYLOAD;
            end
        end else begin
            r.payload_valid = 1'b1;
            r.payload_byte = b;
            r.frame_kind = fr_is_cmd;
            r.frame_length = fr_len;
            if ({1'b0, fr_pos} + 18'd1 >= {2'b00, fr_len} + 18'd4) begin
                r.frame_done = 1'b1;
                fr_pos = POS_SYNC;
                if (fr_is_cmd) fr_window = 1'b0;
            end else begin
                fr_pos = fr_pos + 17'd1;
            end
        end
        r.window_active = fr_window;
        return r;
    endfunction

    // register write as seen by the shadow copy
    function automatic void apply_reg(input logic [2:0] idx, input logic [15:0] val);
        case (idx)
            CFG_SYNC_BYTE:      shadow_cfg.sync_byte = val[7:0];
            CFG_STD_TYPE_BYTE:  shadow_cfg.std_type_byte = val[7:0];
            CFG_CMD_TYPE_BYTE:  shadow_cfg.cmd_type_byte = val[7:0];
            CFG_MAX_STD_LENGTH: shadow_cfg.max_std_length = val;
            CFG_MAX_CMD_LENGTH: shadow_cfg.max_cmd_length = val;
            CFG_STALL_TIMEOUT:  shadow_cfg.stall_timeout = val;
            default: ;
        endcase
    endfunction

    // one input request, with random idle cycles ahead of it
    task automatic send_item(input logic req, input logic [7:0] b);
        while (!no_idle && $urandom_range(0, 99) < 25) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= req;
        s_axis_tdata <= b;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        pending_results.push_back(decode_step(req, b));
        sent_count++;
    endtask

    task automatic send_bytes(input logic [7:0] bytes[$]);
        foreach (bytes[k]) send_item(REQ_BYTE, bytes[k]);
    endtask

    // stop offering and let every outstanding result drain
    task automatic settle_block();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
        settle_block();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        apply_reg(idx, val);
    endtask

    // a tick now and then between bytes
    task automatic maybe_tick();
        if ($urandom_range(0, 99) < 12) send_item(REQ_TICK, 8'($urandom));
    endtask

    // mostly well-formed frames with random content, some noise and broken headers
    task automatic send_random_frame();
        int          roll;
        logic        cmd;
        int          lim;
        int          len;
        logic [7:0]  bad;
        roll = $urandom_range(0, 99);
        maybe_tick();
        if (roll < 8) begin
            send_item(REQ_BYTE, 8'($urandom));
            return;
        end
        send_item(REQ_BYTE, shadow_cfg.sync_byte);
        maybe_tick();
        if (roll < 15) begin
            do bad = 8'($urandom);
            while (bad == shadow_cfg.std_type_byte || bad == shadow_cfg.cmd_type_byte);
            if (roll < 10) bad = shadow_cfg.sync_byte == shadow_cfg.std_type_byte ||
                                 shadow_cfg.sync_byte == shadow_cfg.cmd_type_byte ?
                                 bad : shadow_cfg.sync_byte;
            send_item(REQ_BYTE, bad);
            return;
        end
        cmd = 1'($urandom_range(0, 1));
        send_item(REQ_BYTE, cmd ? shadow_cfg.cmd_type_byte : shadow_cfg.std_type_byte);
        lim = cmd ? shadow_cfg.max_cmd_length : shadow_cfg.max_std_length;
        if (lim < 256 && $urandom_range(0, 99) < 5) len = $urandom_range(256, 65535);
        else len = $urandom_range(0, (lim > 16 ? 16 : lim) + 2);
        maybe_tick();
        send_item(REQ_BYTE, 8'(len >> 8));
        maybe_tick();
        send_item(REQ_BYTE, 8'(len));
        if (len <= lim) begin
            for (int k = 0; k < len; k++) begin
                maybe_tick();
                send_item(REQ_BYTE, 8'($urandom));
            end
        end
    endtask

    // random register set, extremes mixed in
    task automatic random_config();
        logic [7:0] std_type;
        std_type = 8'($urandom);
        write_reg(CFG_SYNC_BYTE, 16'($urandom_range(0, 255)));
        write_reg(CFG_STD_TYPE_BYTE, {8'h00, std_type});
        write_reg(CFG_CMD_TYPE_BYTE, $urandom_range(0, 9) == 0 ? {8'h00, std_type}
                                                               : 16'($urandom_range(0, 255)));
        write_reg(CFG_MAX_STD_LENGTH, $urandom_range(0, 5) == 0 ? 16'hFFFF
                                                                : 16'($urandom_range(0, 16)));
        write_reg(CFG_MAX_CMD_LENGTH, $urandom_range(0, 5) == 0 ? 16'hFFFF
                                                                : 16'($urandom_range(0, 16)));
        case ($urandom_range(0, 9))
            0:       write_reg(CFG_STALL_TIMEOUT, 16'd0);
            1:       write_reg(CFG_STALL_TIMEOUT, 16'hFFFF);
            default: write_reg(CFG_STALL_TIMEOUT, 16'($urandom_range(1, 24)));
        endcase
    endtask

    // reset defaults: a standard frame and an over-long command frame
    task automatic test_default_frames();
        send_bytes('{8'd148, 8'd195, 8'h00, 8'h02, 8'h00, 8'hFF});
        send_bytes('{8'd148, 8'h00, 8'h01, 8'h01});
    endtask

    // wrong sync, wrong type, sync in the type slot, idle tick
    task automatic test_header_errors();
        send_bytes('{8'h10, 8'd148, 8'h55, 8'd148, 8'd148});
        send_item(REQ_TICK, 8'hA5);
    endtask

    // every register at an extreme, equal type bytes, zero timeout
    task automatic test_register_extremes();
        write_reg(CFG_SYNC_BYTE, 16'h0000);
        write_reg(CFG_STD_TYPE_BYTE, 16'h00FF);
        write_reg(CFG_CMD_TYPE_BYTE, 16'h00FF);
        write_reg(CFG_MAX_STD_LENGTH, 16'h0000);
        write_reg(CFG_MAX_CMD_LENGTH, 16'hFFFF);
        write_reg(CFG_STALL_TIMEOUT, 16'h0000);
        // equal type bytes decode as standard: empty frame, then one over limit
        send_bytes('{8'h00, 8'hFF, 8'h00, 8'h00});
        send_bytes('{8'h00, 8'hFF, 8'h00, 8'h01});
        write_reg(CFG_CMD_TYPE_BYTE, 16'h0000);
        // longest command frame, aborted by the first tick
        send_bytes('{8'h00, 8'h00, 8'hFF, 8'hFF, 8'h5A});
        send_item(REQ_TICK, 8'h00);
        settle_block();
    endtask

    // receiver holds off while the sender keeps offering
    task automatic test_output_stall();
        no_idle = 1'b1;
        hold_req = 1'b1;
        for (int k = 0; k < 12; k++) send_random_frame();
        no_idle = 1'b0;
        settle_block();
    endtask

    task automatic test_random_traffic();
        int target;
        target = sent_count;
        for (int phase = 0; phase < 5; phase++) begin
            random_config();
            no_idle = (phase == 2);
            target += RANDOM_ITEMS / 5;
            while (sent_count < target) send_random_frame();
            no_idle = 1'b0;
        end
        settle_block();
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            errors++;
        end
    endtask

    // compare each accepted result with the oldest prediction
    always @(posedge i_clk) begin : result_check
        t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_results.size() == 0) begin
                $error("result with no request outstanding: tdata %h", m_axis_tdata);
                errors++;
            end else begin
                want = pending_results.pop_front();
                check_field("payload_valid", want.payload_valid, m_axis_tuser[0]);
                check_field("payload_byte", want.payload_byte, m_axis_tdata[7:0]);
                check_field("frame_kind", want.frame_kind, m_axis_tuser[1]);
                check_field("frame_done", want.frame_done, m_axis_tlast);
                check_field("frame_length", want.frame_length, m_axis_tdata[23:8]);
                check_field("status", int'(want.status), m_axis_tdata[25:24]);
                check_field("window_active", want.window_active, m_axis_tdata[26]);
            end
        end
    end

    // result sink: random stalls, long hold-off on request
    initial begin : result_sink
        int hold_left;
        hold_left = 0;
        m_axis_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= no_idle || ($urandom_range(0, 99) >= 25);
            end
        end
    end

    // watchdog on cycles without any handshake
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        i_rst_n <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata <= '0;
        s_axis_tuser <= REQ_BYTE;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= CFG_SYNC_BYTE;
        i_cfg_data <= '0;
        quiet_cycles = 0;
        errors = 0;
        sent_count = 0;
        no_idle = 1'b0;
        hold_req = 1'b0;
        shadow_cfg = '{sync_byte: 8'd148, std_type_byte: 8'd195, cmd_type_byte: 8'd0,
                       max_std_length: 16'd512, max_cmd_length: 16'd256,
                       stall_timeout: 16'd1000};
        fr_pos = POS_SYNC;
        fr_len_hi = '0;
        fr_len = '0;
        fr_is_cmd = 1'b0;
        fr_window = 1'b0;
        fr_ticks = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_default_frames();
        test_header_errors();
        test_register_extremes();
        test_output_stall();
        test_random_traffic();

        // final drain, then keep clocking to catch stray results
        settle_block();
        repeat (10) @(posedge i_clk);
        if (errors == 0 && pending_results.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/slfr_pkg.sv
rtl/slfr_cfg_regs.sv
rtl/slfr_in_reg.sv
rtl/slfr_parser.sv
rtl/slfr_out_reg.sv
rtl/sync_length_frame_receiver.sv
test/sync_length_frame_receiver_tb.sv
